// ===== sv/d256fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// d256fmt_pkg: shared types and constants for the decimal256 formatter
// Beat types, status codes, ASCII constants and derived widths used by the
// check-and-format block.
// ----------------------------------------------------------------------------
package d256fmt_pkg;

    // largest legal precision and scale
    localparam int MAX_DIGITS     = 76;
    // characters carried by one output beat
    localparam int BYTES_PER_BEAT = 8;

    // unscaled value width and the BCD digits its magnitude needs (2^255 has 77)
    localparam int VALUE_W     = 256;
    localparam int BCD_DIGITS  = 77;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);
    localparam int BIT_CNT_W   = $clog2(VALUE_W);

    // output field widths
    localparam int TEXT_W      = 64;
    localparam int BEAT_CNT_W  = 4;
    localparam int BEAT_IDX_W  = (BYTES_PER_BEAT > 1) ? $clog2(BYTES_PER_BEAT) : 1;

    // ascii characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        STATUS_OK             = 2'd0,
        STATUS_BAD_PRECISION  = 2'd1,
        STATUS_BAD_SCALE      = 2'd2,
        STATUS_TOO_MANY_DIGITS = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] value_word0;
        logic [63:0] value_word1;
        logic [63:0] value_word2;
        logic [63:0] value_word3;
        logic [7:0]  precision;
        logic [7:0]  scale;
    } in_t;

    typedef struct packed {
        logic [TEXT_W-1:0]     text_bytes;
        logic [BEAT_CNT_W-1:0] byte_count;
        logic                  last_beat;
        status_t               status;
    } out_t;

endpackage

// ===== sv/decimal256_check_and_format.sv =====
// ----------------------------------------------------------------------------
// decimal256_check_and_format: decimal256 range check and text formatter
// Converts a signed 256-bit unscaled value to decimal text with its scale,
// after checking precision, scale and digit count.
// ----------------------------------------------------------------------------
// One item at a time. After acceptance the magnitude is shifted bit-serially,
// MSB first, through a double-dabble BCD register, with the two's complement
// negation folded into the bit stream. A check state then runs the checks.
// An error gives a single beat with byte_count 0 and last_beat set.
// Otherwise one character is produced per cycle (sign, leading "0." and
// zeros, digits and point), stalling while a full beat or the last character
// waits for the output side, and packed into beats of BYTES_PER_BEAT bytes.
// The next item is taken once the last character has been handed to the
// output register.
module decimal256_check_and_format
    import d256fmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CONV  = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_SIGN  = 8'b0000_1000,
        ST_LEAD  = 8'b0001_0000,
        ST_POINT = 8'b0010_0000,
        ST_ZERO  = 8'b0100_0000,
        ST_DIGIT = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     bin_reg, bin_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [DIGIT_IDX_W-1:0] hi_reg, hi_next;
    logic [7:0]             prec_reg, prec_next;
    logic [7:0]             scale_reg, scale_next;
    logic                   lead_reg, lead_next;
    logic [DIGIT_IDX_W-1:0] zcnt_reg, zcnt_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [TEXT_W-1:0]      pack_reg, pack_next;
    logic [BEAT_CNT_W-1:0]  pack_cnt_reg, pack_cnt_next;
    out_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   mag_bit;
    logic [BCD_W-1:0]       bcd_adj;
    logic                   carry_hi;
    logic [7:0]             digit_cnt;
    status_t                chk_status;
    logic                   lead;
    logic [3:0]             cur_digit;
    logic                   char_valid;
    logic [7:0]             char_byte;
    logic                   char_last;
    state_t                 char_after;
    logic                   out_free;
    logic                   flush;
    logic                   step;
    logic [TEXT_W-1:0]      pack_fill;
    logic [BEAT_IDX_W-1:0]  pack_pos;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // magnitude bit, MSB first: negation flips a bit when any lower bit is set
    assign mag_bit = bin_reg[VALUE_W-1] ^ (neg_reg & (|bin_reg[VALUE_W-2:0]));

    // double-dabble add-3 correction on every digit
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    // the top significant digit carries into the next one on this shift
    assign carry_hi = bcd_adj[{hi_reg, 2'b11}];

    // checks, precision first, then scale, then digit count
    assign digit_cnt = {1'b0, hi_reg} + 8'd1;
    always_comb
    begin
        if (prec_reg == 8'd0 || prec_reg > 8'(MAX_DIGITS))
        begin
            chk_status = STATUS_BAD_PRECISION;
        end
        else if (scale_reg > 8'(MAX_DIGITS))
        begin
            chk_status = STATUS_BAD_SCALE;
        end
        else if (digit_cnt > prec_reg)
        begin
            chk_status = STATUS_TOO_MANY_DIGITS;
        end
        else
        begin
            chk_status = STATUS_OK;
        end
    end

    // "0." form when every digit sits after the point
    assign lead = (scale_reg != 8'd0) && (digit_cnt <= scale_reg);

    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    // character generator, one character per cycle unless a flush is held by the output side
    always_comb
    begin
        char_valid = 1'b1;
        char_byte  = CHAR_ZERO;
        char_last  = 1'b0;
        char_after = state_reg;
        unique case (state_reg)
            ST_SIGN:
            begin
                char_byte  = CHAR_MINUS;
                char_after = lead_reg ? ST_LEAD : ST_DIGIT;
            end
            ST_LEAD:
            begin
                char_byte  = CHAR_ZERO;
                char_after = ST_POINT;
            end
            ST_POINT:
            begin
                char_byte  = CHAR_POINT;
                char_after = (zcnt_reg != '0) ? ST_ZERO : ST_DIGIT;
            end
            ST_ZERO:
            begin
                char_byte  = CHAR_ZERO;
                char_after = (zcnt_reg == DIGIT_IDX_W'(1)) ? ST_DIGIT : ST_ZERO;
            end
            ST_DIGIT:
            begin
                char_byte = CHAR_ZERO + {4'b0000, cur_digit};
                char_last = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    char_after = ST_IDLE;
                end
                else if ({1'b0, idx_reg} == scale_reg)
                begin
                    char_after = ST_POINT;
                end
                else
                begin
                    char_after = ST_DIGIT;
                end
            end
            default:
            begin
                char_valid = 1'b0;
            end
        endcase
    end

    // beat packing: a full beat or the final character needs the output register
    assign pack_pos = pack_cnt_reg[BEAT_IDX_W-1:0];
    assign flush    = char_last || (pack_cnt_reg == BEAT_CNT_W'(BYTES_PER_BEAT - 1));
    assign step     = char_valid && (!flush || out_free);

    always_comb
    begin
        pack_fill = pack_reg;
        pack_fill[{pack_pos, 3'b000} +: 8] = char_byte;
    end

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        bcd_next       = bcd_reg;
        hi_next        = hi_reg;
        prec_next      = prec_reg;
        scale_next     = scale_reg;
        lead_next      = lead_reg;
        zcnt_next      = zcnt_reg;
        idx_next       = idx_reg;
        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next     = {in_data.value_word3, in_data.value_word2,
                                    in_data.value_word1, in_data.value_word0};
                    neg_next     = in_data.value_word3[63];
                    prec_next    = in_data.precision;
                    scale_next   = in_data.scale;
                    bcd_next     = '0;
                    hi_next      = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_W - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_bit};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (carry_hi && hi_reg != DIGIT_IDX_W'(BCD_DIGITS - 1))
                begin
                    hi_next = hi_reg + 1'b1;
                end
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_status != STATUS_OK)
                begin
                    if (out_free)
                    begin
                        out_next.text_bytes = '0;
                        out_next.byte_count = '0;
                        out_next.last_beat  = 1'b1;
                        out_next.status     = chk_status;
                        out_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    lead_next     = lead;
                    zcnt_next     = lead ? DIGIT_IDX_W'(scale_reg - digit_cnt) : '0;
                    idx_next      = hi_reg;
                    pack_next     = '0;
                    pack_cnt_next = '0;
                    if (neg_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else if (lead)
                    begin
                        state_next = ST_LEAD;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_SIGN, ST_LEAD, ST_POINT, ST_ZERO, ST_DIGIT:
            begin
                if (step)
                begin
                    state_next = char_after;
                    if (state_reg == ST_ZERO)
                    begin
                        zcnt_next = zcnt_reg - 1'b1;
                    end
                    if (state_reg == ST_DIGIT && !char_last)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                    if (flush)
                    begin
                        out_next.text_bytes = pack_fill;
                        out_next.byte_count = pack_cnt_reg + 1'b1;
                        out_next.last_beat  = char_last;
                        out_next.status     = STATUS_OK;
                        out_valid_next      = 1'b1;
                        pack_next           = '0;
                        pack_cnt_next       = '0;
                    end
                    else
                    begin
                        pack_next     = pack_fill;
                        pack_cnt_next = pack_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            hi_reg        <= '0;
            pack_cnt_reg  <= '0;
            zcnt_reg      <= '0;
            idx_reg       <= '0;
            lead_reg      <= 1'b0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            hi_reg        <= hi_next;
            pack_cnt_reg  <= pack_cnt_next;
            zcnt_reg      <= zcnt_next;
            idx_reg       <= idx_next;
            lead_reg      <= lead_next;
            neg_reg       <= neg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        prec_reg  <= prec_next;
        scale_reg <= scale_next;
        pack_reg  <= pack_next;
        out_reg   <= out_next;
    end

    // an error beat is always the only and final beat, with no characters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_OK
            |-> out_data.last_beat && out_data.byte_count == '0)
        else $error("error beat malformed");

    // a text beat carries between one and BYTES_PER_BEAT characters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_OK
            |-> out_data.byte_count != '0
                && out_data.byte_count <= BEAT_CNT_W'(BYTES_PER_BEAT))
        else $error("text beat count out of range");

    // conversion ends after the last bit is shifted in
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && bit_cnt_reg == '0 |=> state_reg == ST_CHECK)
        else $error("conversion did not hand over to check");

    // an accepted item starts the conversion with a full bit count
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
            |=> state_reg == ST_CONV && bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
        else $error("conversion not started");

    // the packing buffer never holds a full beat
    assert property (@(posedge clk) disable iff (!rst_n)
        pack_cnt_reg < BEAT_CNT_W'(BYTES_PER_BEAT))
        else $error("packing buffer overfilled");

endmodule

// ===== verif/decimal256_check_and_format_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal256_check_and_format_checker: text beat predictor and comparator
// Watches both channels of the formatter. Every accepted input beat is turned
// into the text beats it should produce, and every accepted output beat is
// checked field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module decimal256_check_and_format_checker
    import d256fmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   fail_count,
    output int   expected_left
);

    out_t text_beat_q[$];
    int   beat_index;

    initial
    begin
        fail_count    = 0;
        expected_left = 0;
        beat_index    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("%0t: output beat %0d: %s mismatch, got %h expected %h",
                 $realtime, beat_index, what, got, want);
    endtask

    // expected text beats for one input, or a single error beat
    function automatic void predict_text(input in_t item);
        logic [255:0] raw;
        logic [255:0] mag;
        logic [3:0]   rev_digit [0:79];
        logic [7:0]   chars [0:95];
        int           ndig;
        int           len;
        int           pos;
        int           n;
        int           z;
        int           b;
        bit           neg;
        out_t         beat;

        raw = {item.value_word3, item.value_word2, item.value_word1, item.value_word0};
        neg = raw[255];
        mag = neg ? -raw : raw;

        // decimal digits, least significant first; zero still counts one
        ndig = 0;
        do
        begin
            rev_digit[ndig] = 4'(mag % 10);
            mag = mag / 10;
            ndig++;
        end while (mag != 0 && ndig < 80);

        // checks in priority order, only the first failure is reported
        beat = '0;
        beat.last_beat = 1'b1;
        if (item.precision == 0 || item.precision > MAX_DIGITS)
        begin
            beat.status = STATUS_BAD_PRECISION;
            text_beat_q.push_back(beat);
            return;
        end
        if (item.scale > MAX_DIGITS)
        begin
            beat.status = STATUS_BAD_SCALE;
            text_beat_q.push_back(beat);
            return;
        end
        if (ndig > item.precision)
        begin
            beat.status = STATUS_TOO_MANY_DIGITS;
            text_beat_q.push_back(beat);
            return;
        end

        // character string
        len = 0;
        if (neg)
        begin
            chars[len] = CHAR_MINUS;
            len = len + 1;
        end
        if (item.scale == 0)
        begin
            while (ndig != 0)
            begin
                ndig = ndig - 1;
                chars[len] = CHAR_ZERO + rev_digit[ndig];
                len = len + 1;
            end
        end
        else
        begin
            if (ndig <= item.scale)
            begin
                chars[len] = CHAR_ZERO;
                chars[len + 1] = CHAR_POINT;
                len = len + 2;
                for (z = ndig; z < item.scale; z++)
                begin
                    chars[len] = CHAR_ZERO;
                    len = len + 1;
                end
            end
            else
            begin
                while (ndig > item.scale)
                begin
                    ndig = ndig - 1;
                    chars[len] = CHAR_ZERO + rev_digit[ndig];
                    len = len + 1;
                end
                chars[len] = CHAR_POINT;
                len = len + 1;
            end
            while (ndig != 0)
            begin
                ndig = ndig - 1;
                chars[len] = CHAR_ZERO + rev_digit[ndig];
                len = len + 1;
            end
        end

        // pack into beats, first character in the low byte
        pos = 0;
        while (pos < len)
        begin
            n = (len - pos > BYTES_PER_BEAT) ? BYTES_PER_BEAT : len - pos;
            beat = '0;
            for (b = 0; b < n; b++)
                beat.text_bytes[8*b +: 8] = chars[pos + b];
            pos += n;
            beat.byte_count = BEAT_CNT_W'(n);
            beat.last_beat  = (pos >= len);
            beat.status     = STATUS_OK;
            text_beat_q.push_back(beat);
        end
    endfunction

    // compare output beats first, then log new input beats
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (text_beat_q.size() == 0)
                    report_mismatch("unexpected beat", out_data.text_bytes, '0);
                else
                begin
                    want = text_beat_q.pop_front();
                    if (out_data.text_bytes !== want.text_bytes)
                        report_mismatch("text_bytes", out_data.text_bytes, want.text_bytes);
                    if (out_data.byte_count !== want.byte_count)
                        report_mismatch("byte_count", 64'(out_data.byte_count),
                                        64'(want.byte_count));
                    if (out_data.last_beat !== want.last_beat)
                        report_mismatch("last_beat", 64'(out_data.last_beat),
                                        64'(want.last_beat));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 64'(out_data.status), 64'(want.status));
                end
                beat_index++;
            end
            if (in_valid && in_ready)
                predict_text(in_data);
            expected_left = text_beat_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: decimal256 check and format
// Drives directed corner values and then random decimals, mostly well-formed
// with some out-of-range precision, scale and digit counts, through the
// formatter with bursty input and a stalling output side. The checker module
// predicts and compares the text beats and returns its failure count.
// ----------------------------------------------------------------------------
module testbench;
    import d256fmt_pkg::*;

    localparam int RANDOM_ITEMS = 460;
    localparam int DRAIN_CYCLES = 400;

    // output ready patterns
    localparam int READY_ALWAYS   = 0;
    localparam int READY_HALF     = 1;
    localparam int READY_SPARSE   = 2;
    localparam int READY_WINDOWED = 3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int   fail_count;
    int   expected_left;
    int   burst_left;

    decimal256_check_and_format uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    decimal256_check_and_format_checker format_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    // 10 ns clock
    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [255:0] pow10(input int n);
        logic [255:0] acc;
        int           k;
        acc = 1;
        for (k = 0; k < n; k++)
            acc = acc * 10;
        return acc;
    endfunction

    function automatic logic [255:0] random_bits();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // random magnitude with exactly ndig decimal digits, ndig 1..77
    function automatic logic [255:0] digits_value(input int ndig);
        logic [255:0] mag;
        int           pick;
        int           k;
        pick = $urandom_range(0, 9);
        if (ndig >= 77)
        begin
            // at least 2^254, still below 2^255
            mag = random_bits();
            mag[255:254] = 2'b01;
        end
        else if (pick == 0)
            mag = pow10(ndig - 1);
        else if (pick == 1)
            mag = pow10(ndig) - 1;
        else
        begin
            mag = $urandom_range(1, 9);
            for (k = 1; k < ndig; k++)
                mag = mag * 10 + $urandom_range(0, 9);
        end
        return mag;
    endfunction

    function automatic in_t build_item(input logic [255:0] raw, input int prec,
                                       input int scl);
        in_t item;
        {item.value_word3, item.value_word2, item.value_word1, item.value_word0} = raw;
        item.precision = 8'(prec);
        item.scale     = 8'(scl);
        return item;
    endfunction

    // mostly legal decimals with random content, then error cases and noise
    function automatic in_t make_random_decimal();
        logic [255:0] mag;
        int           kind;
        int           prec;
        int           scl;
        int           ndig;
        kind = $urandom_range(0, 99);
        prec = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 10)
                                            : $urandom_range(1, MAX_DIGITS);
        ndig = $urandom_range(1, prec);
        case ($urandom_range(0, 4))
            0: scl = 0;
            1: scl = $urandom_range(1, 10);
            2: scl = $urandom_range(0, MAX_DIGITS);
            3: scl = ndig - 1 + $urandom_range(0, 2);
            default: scl = MAX_DIGITS;
        endcase
        if (scl > MAX_DIGITS)
            scl = MAX_DIGITS;
        mag = ($urandom_range(0, 19) == 0) ? '0 : digits_value(ndig);

        if (kind < 65)
        begin
            // well-formed, values as drawn
        end
        else if (kind < 75)
        begin
            // one digit or more beyond the precision
            prec = $urandom_range(1, MAX_DIGITS);
            mag = digits_value($urandom_range(prec + 1, 77));
            if ($urandom_range(0, 7) == 0)
                mag = {1'b1, 255'b0};
        end
        else if (kind < 82)
        begin
            case ($urandom_range(0, 3))
                0: prec = 0;
                1: prec = MAX_DIGITS + 1;
                2: prec = 255;
                default: prec = $urandom_range(MAX_DIGITS + 1, 255);
            endcase
        end
        else if (kind < 89)
            scl = ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(MAX_DIGITS + 1, 255);
        else
        begin
            // raw noise over every bit of every field
            mag  = random_bits();
            prec = $urandom_range(0, 255);
            scl  = $urandom_range(0, 255);
            return build_item(mag, prec, scl);
        end
        return build_item(($urandom_range(0, 1) == 1) ? -mag : mag, prec, scl);
    endfunction

    // hold one input beat until it is taken
    task automatic send_item(input in_t item);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end while (!in_ready);
    endtask

    task automatic send_value(input logic [255:0] raw, input int prec, input int scl);
        send_item(build_item(raw, prec, scl));
    endtask

    // bursts of random length with random gaps in between
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 5);
                2: gap = $urandom_range(5, 60);
                default: gap = $urandom_range(60, 400);
            endcase
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // stop sending until every expected beat has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
    endtask

    // output side stalls on a pattern that changes mode now and then
    initial
    begin
        int mode;
        int hold;
        out_ready = 1'b0;
        mode = READY_ALWAYS;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(READY_ALWAYS, READY_WINDOWED);
                hold = $urandom_range(20, 400);
            end
            hold--;
            case (mode)
                READY_ALWAYS:   out_ready <= 1'b1;
                READY_HALF:     out_ready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
                default:        out_ready <= ((hold % 32) < 4);
            endcase
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [255:0] nines76;
        int           i;
        in_valid   = 1'b0;
        in_data    = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        nines76    = pow10(MAX_DIGITS) - 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero, unit and widest legal values
        send_value(0, 1, 0);
        send_value(0, 1, MAX_DIGITS);
        send_value(0, MAX_DIGITS, 3);
        send_value(1, 1, 0);
        send_value(-1, 1, 1);
        send_value(nines76, MAX_DIGITS, 0);
        send_value(-nines76, MAX_DIGITS, MAX_DIGITS);
        send_value(nines76, MAX_DIGITS, 38);
        // digit count beyond precision, most negative and largest positive
        send_value(pow10(MAX_DIGITS), MAX_DIGITS, 0);
        send_value({1'b1, 255'b0}, MAX_DIGITS, 0);
        send_value({1'b0, {255{1'b1}}}, MAX_DIGITS, 10);
        send_value(1234, 3, 0);
        // precision and scale range errors, precision wins over scale
        send_value(123, 0, 0);
        send_value(123, MAX_DIGITS + 1, 0);
        send_value({256{1'b1}}, 255, 255);
        send_value(123, 10, MAX_DIGITS + 1);
        send_value(pow10(20), 5, 255);
        // precision below scale, digits equal to and just above scale
        send_value(123, 3, 5);
        send_value(-12345, 5, 5);
        send_value(12345, 5, 4);
        // beat boundaries
        send_value(12345678, 8, 0);
        send_value(-1234567, 7, 0);
        send_value(-123456789, 9, 0);
        drain_results();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pace_sender();
            send_item(make_random_decimal());
            if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("decimal256_check_and_format test passed");
        else
            $display("decimal256_check_and_format test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(20_000_000);
        $display("decimal256_check_and_format test failed");
        $finish;
    end

endmodule
